>>> rtl/script_lexer_byte_stream_assert.svh
// Assertion macros shared by the scanner RTL.
// Each macro expands to one labeled concurrent assertion clocked on the given clock.
`ifndef SCRIPT_LEXER_BYTE_STREAM_ASSERT_SVH
`define SCRIPT_LEXER_BYTE_STREAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SLX_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define SLX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/slx_pkg.sv
// Shared types, token codes, keyword table and character helpers for the scanner.
// No dependencies; used by slx_scan, slx_tokq and script_lexer_byte_stream.
package slx_pkg;

    localparam int POSITION_BITS      = 32;
    localparam int KEYWORD_PREFIX_LEN = 6;
    // Token queue depth; must be a power of two (pointers wrap naturally).
    localparam int TOKQ_DEPTH         = 8;
    localparam int TOKQ_CNT_W         = $clog2(TOKQ_DEPTH + 1);

    // Token kind codes
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_SLASH   = 6'd9;
    localparam logic [5:0] K_BANG    = 6'd11;
    localparam logic [5:0] K_EQUAL   = 6'd13;
    localparam logic [5:0] K_GREATER = 6'd15;
    localparam logic [5:0] K_LESS    = 6'd17;
    localparam logic [5:0] K_IDENT   = 6'd19;
    localparam logic [5:0] K_STRING  = 6'd20;
    localparam logic [5:0] K_NUMBER  = 6'd21;
    localparam logic [5:0] K_ERROR   = 6'd38;
    localparam logic [5:0] K_EOF     = 6'd39;

    // Error kind codes
    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM     = 2'd2;

    typedef struct packed {
        logic [31:0] line;
        logic [31:0] len;
        logic [31:0] start;
        logic [1:0]  err;
        logic [5:0]  kind;
        logic        last;
    } tok_t;

    // Up to three tokens produced by one input beat, in order
    typedef struct packed {
        logic [1:0]      n;
        tok_t [2:0]      tok;
    } push_t;

    typedef struct packed {
        logic [TOKQ_CNT_W-1:0] count;
        logic                  room;
    } tokq_stat_t;

    // Keyword text is right-justified, first character in the highest used byte
    typedef struct packed {
        logic [47:0] text;
        logic [2:0]  len;
        logic [5:0]  kind;
    } kw_t;

    localparam kw_t KW_TABLE [16] = '{
        '{48'("and"),    3'd3, 6'd22}, '{48'("class"),  3'd5, 6'd23},
        '{48'("else"),   3'd4, 6'd24}, '{48'("false"),  3'd5, 6'd25},
        '{48'("for"),    3'd3, 6'd26}, '{48'("fun"),    3'd3, 6'd27},
        '{48'("if"),     3'd2, 6'd28}, '{48'("nil"),    3'd3, 6'd29},
        '{48'("or"),     3'd2, 6'd30}, '{48'("print"),  3'd5, 6'd31},
        '{48'("return"), 3'd6, 6'd32}, '{48'("super"),  3'd5, 6'd33},
        '{48'("this"),   3'd4, 6'd34}, '{48'("true"),   3'd4, 6'd35},
        '{48'("var"),    3'd3, 6'd36}, '{48'("while"),  3'd5, 6'd37}
    };

    // Keyword lookup on the first len prefix bytes; identifier when nothing hits
    function automatic logic [5:0] kw_kind(input logic [5:0][7:0] p, input logic [2:0] len);
        logic [5:0] k;
        logic       hit;
        k = K_IDENT;
        for (int j = 0; j < 16; j++) begin
            hit = (KW_TABLE[j].len == len);
            for (int i = 0; i < 6; i++) begin
                if (hit && (i < int'(len))) begin
                    hit = (p[i] == KW_TABLE[j].text[8*(int'(len)-1-i) +: 8]);
                end
            end
            if (hit) begin
                k = KW_TABLE[j].kind;
            end
        end
        return k;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c == 8'h5F) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Single-character punctuation; K_ERROR when the byte is not one of them
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h28:   k = 6'd0;   // (
            8'h29:   k = 6'd1;   // )
            8'h7B:   k = 6'd2;   // {
            8'h7D:   k = 6'd3;   // }
            8'h2C:   k = 6'd4;   // ,
            8'h2E:   k = K_DOT;
            8'h2D:   k = 6'd6;   // -
            8'h2B:   k = 6'd7;   // +
            8'h3B:   k = 6'd8;   // ;
            8'h2A:   k = 6'd10;  // *
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] op, input logic with_eq);
        logic [5:0] base;
        case (op)
            8'h21:   base = K_BANG;
            8'h3D:   base = K_EQUAL;
            8'h3E:   base = K_GREATER;
            default: base = K_LESS;
        endcase
        return base + {5'd0, with_eq};
    endfunction

endpackage

>>> rtl/slx_scan.sv
// Scanner state and the per-byte step: mode, held operator, counters, word prefix.
// Depends on slx_pkg; produces up to three tokens per accepted beat.
module slx_scan #(
    parameter int POS_BITS = slx_pkg::POSITION_BITS,
    parameter int KPL      = slx_pkg::KEYWORD_PREFIX_LEN
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_beat,
    input  logic [7:0]     char_byte,
    input  logic           end_of_input,
    output slx_pkg::push_t push
);
    import slx_pkg::*;

    localparam int POS_W  = (POS_BITS < 32) ? POS_BITS : 32;
    localparam int PFX_IW = $clog2(KPL);

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_OP, M_IDENT,
        M_NUMBER, M_NUMDOT, M_FRAC, M_STRING
    } mode_t;

    mode_t             mode_reg,  mode_next;
    logic [7:0]        held_reg,  held_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [POS_W-1:0]  start_reg, start_next;
    logic [31:0]       line_reg,  line_next;
    logic [7:0]        pfx_reg [KPL];

    logic              end_now, again, line_inc, pfx_we;
    logic [PFX_IW-1:0] pfx_idx;
    logic [POS_W-1:0]  span, dot, dot_span;
    logic [5:0][7:0]   pfx6;
    logic [5:0]        word_k, sk;
    logic [1:0]        fl_n, n;
    tok_t [1:0]        fl;
    tok_t [2:0]        toks;
    logic [31:0]       str_len;

    function automatic tok_t mk(input logic [5:0] k, input logic [1:0] e,
                                input logic [POS_W-1:0] s, input logic [31:0] l,
                                input logic [31:0] ln);
        tok_t t;
        t.kind  = k;
        t.err   = e;
        t.start = 32'(s);
        t.len   = l;
        t.line  = ln;
        t.last  = 1'b0;
        return t;
    endfunction

    // Word length so far, dot position for "1." and keyword lookup
    always_comb begin
        span     = (pos_reg >= start_reg) ? pos_reg - start_reg : '0;
        dot      = (pos_reg != '0) ? pos_reg - 1'b1 : '0;
        dot_span = (dot >= start_reg) ? dot - start_reg : '0;
        for (int i = 0; i < 6; i++) begin
            pfx6[i] = pfx_reg[i];
        end
        word_k  = (span <= POS_W'(6)) ? kw_kind(pfx6, span[2:0]) : K_IDENT;
        str_len = (32'(span) != '1) ? 32'(span) + 32'd1 : 32'(span);
        sk      = single_kind(char_byte);
    end

    // Tokens owed by the current mode when a byte ends it
    always_comb begin
        fl_n = 2'd0;
        fl   = '0;
        case (mode_reg)
            M_SLASH: begin
                fl[0] = mk(K_SLASH, E_NONE, start_reg, 32'd1, line_reg);
                fl_n  = 2'd1;
            end
            M_OP: begin
                fl[0] = mk(op_kind(held_reg, 1'b0), E_NONE, start_reg, 32'd1, line_reg);
                fl_n  = 2'd1;
            end
            M_IDENT: begin
                fl[0] = mk(word_k, E_NONE, start_reg, 32'(span), line_reg);
                fl_n  = 2'd1;
            end
            M_NUMBER, M_FRAC: begin
                fl[0] = mk(K_NUMBER, E_NONE, start_reg, 32'(span), line_reg);
                fl_n  = 2'd1;
            end
            M_NUMDOT: begin
                fl[0] = mk(K_NUMBER, E_NONE, start_reg, 32'(dot_span), line_reg);
                fl[1] = mk(K_DOT, E_NONE, dot, 32'd1, line_reg);
                fl_n  = 2'd2;
            end
            M_STRING: begin
                fl[0] = mk(K_ERROR, E_UNTERM, start_reg, 32'(span), line_reg);
                fl_n  = 2'd1;
            end
            default: ;
        endcase
    end

    // One scanner step
    always_comb begin
        end_now    = end_of_input || (char_byte == 8'h00);
        again      = 1'b1;
        line_inc   = 1'b0;
        pfx_we     = 1'b0;
        pfx_idx    = span[PFX_IW-1:0];
        mode_next  = mode_reg;
        held_next  = held_reg;
        start_next = start_reg;
        toks       = '0;
        n          = 2'd0;

        if (end_now) begin
            again = 1'b0;
            toks[0] = fl[0];
            toks[1] = fl[1];
            n = fl_n;
            toks[n] = mk(K_EOF, E_NONE, pos_reg, 32'd0, line_reg);
            n = n + 2'd1;
            mode_next  = M_IDLE;
            held_next  = 8'h00;
            start_next = '0;
        end else begin
            unique case (mode_reg)
                M_SLASH: begin
                    if (char_byte == 8'h2F) begin
                        mode_next = M_COMMENT;
                        again = 1'b0;
                    end
                end
                M_COMMENT: begin
                    if (char_byte != 8'h0A) begin
                        again = 1'b0;
                    end
                end
                M_OP: begin
                    if (char_byte == 8'h3D) begin
                        toks[0] = mk(op_kind(held_reg, 1'b1), E_NONE, start_reg, 32'd2,
                                     line_reg);
                        n = 2'd1;
                        mode_next = M_IDLE;
                        again = 1'b0;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(char_byte) || is_digit(char_byte)) begin
                        pfx_we = (span < POS_W'(KPL));
                        again = 1'b0;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(char_byte)) begin
                        again = 1'b0;
                    end else if (char_byte == 8'h2E) begin
                        mode_next = M_NUMDOT;
                        again = 1'b0;
                    end
                end
                M_NUMDOT: begin
                    if (is_digit(char_byte)) begin
                        mode_next = M_FRAC;
                        again = 1'b0;
                    end
                end
                M_FRAC: begin
                    if (is_digit(char_byte)) begin
                        again = 1'b0;
                    end
                end
                M_STRING: begin
                    again = 1'b0;
                    if (char_byte == 8'h22) begin
                        toks[0] = mk(K_STRING, E_NONE, start_reg, str_len, line_reg);
                        n = 2'd1;
                        mode_next = M_IDLE;
                    end else if (char_byte == 8'h0A) begin
                        line_inc = 1'b1;
                    end
                end
                default: ;
            endcase

            // Byte not consumed: close the pending token, then start afresh
            if (again) begin
                toks[0] = fl[0];
                toks[1] = fl[1];
                n = fl_n;
                mode_next = M_IDLE;
                if (char_byte == 8'h20 || char_byte == 8'h0D || char_byte == 8'h09) begin
                    mode_next = M_IDLE;
                end else if (char_byte == 8'h0A) begin
                    line_inc = 1'b1;
                end else begin
                    start_next = pos_reg;
                    if (char_byte == 8'h2F) begin
                        mode_next = M_SLASH;
                    end else if (is_alpha(char_byte)) begin
                        mode_next = M_IDENT;
                        pfx_we  = 1'b1;
                        pfx_idx = '0;
                    end else if (is_digit(char_byte)) begin
                        mode_next = M_NUMBER;
                    end else if (char_byte == 8'h22) begin
                        mode_next = M_STRING;
                    end else if (char_byte == 8'h21 || char_byte == 8'h3D ||
                                 char_byte == 8'h3C || char_byte == 8'h3E) begin
                        mode_next = M_OP;
                        held_next = char_byte;
                    end else begin
                        toks[n] = mk(sk, (sk == K_ERROR) ? E_UNEXPECTED : E_NONE,
                                     pos_reg, 32'd1, line_reg);
                        n = n + 2'd1;
                    end
                end
            end
        end

        if (n != 2'd0) begin
            toks[n - 2'd1].last = 1'b1;
        end

        // Saturating counters; end of input restarts them
        if (end_now) begin
            pos_next  = '0;
            line_next = 32'd1;
        end else begin
            pos_next  = (pos_reg != '1) ? pos_reg + 1'b1 : pos_reg;
            line_next = (line_inc && line_reg != '1) ? line_reg + 32'd1 : line_reg;
        end

        push.n   = n;
        push.tok = toks;
    end

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            held_reg  <= 8'h00;
            pos_reg   <= '0;
            start_reg <= '0;
            line_reg  <= 32'd1;
        end else if (in_beat) begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            line_reg  <= line_next;
        end
    end

    // Word prefix store, written only as a word is collected
    always_ff @(posedge aclk) begin
        if (in_beat && pfx_we) begin
            pfx_reg[pfx_idx] <= char_byte;
        end
    end

endmodule

>>> rtl/slx_tokq.sv
// Token queue: takes up to three tokens per cycle, hands out one per beat.
// Depends on slx_pkg.
module slx_tokq #(
    parameter int DEPTH = slx_pkg::TOKQ_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  slx_pkg::push_t      push,
    output logic                out_valid,
    input  logic                out_ready,
    output slx_pkg::tok_t       head,
    output slx_pkg::tokq_stat_t stat
);
    import slx_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_in;
    logic             pop;

    // Pointer and occupancy update
    always_comb begin
        pop         = out_valid && out_ready;
        n_in        = wr_en ? CNT_W'(push.n) : '0;
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_in);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + n_in - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: consecutive slots from the write pointer
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (wr_en && (k < int'(push.n))) begin
                mem[wr_ptr_reg + PTR_W'(k)] <= push.tok[k];
            end
        end
    end

    assign out_valid  = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.room  = (count_reg <= CNT_W'(DEPTH - 3));

endmodule

>>> rtl/script_lexer_byte_stream.sv
// Streaming lexical scanner: source bytes in, tokens out.
// Input channel s_*: one source byte per beat; s_tlast marks end of input.
// Output channel m_*: one token per beat; m_tuser carries the token and
// error kinds, m_tlast marks the last token of the input byte that produced it.
// A token completed by a byte is written into the token queue as that byte
// is accepted and offered from its head. Held tokens (operators, words,
// numbers) go out when the following byte or end of input arrives.
// Throughput: one byte per cycle while s_tready is high. Each byte yields
// zero to three tokens; they enter an eight-entry token queue, and s_tready
// drops while fewer than three slots are free, so a steady stream of
// single-token bytes runs at one byte per cycle with a ready receiver and
// multi-token bytes are bounded by the output rate of one token per cycle.
// A stalled receiver only fills the queue; the scanner keeps taking bytes
// until the queue is near full, and no token is dropped.
// End of input (s_tlast or a zero byte) emits pending tokens, then EOF with
// m_tlast, and returns position to 0 and line to 1.
// Reset (aresetn low, synchronous) empties the queue and idles the scanner.
// Depends on slx_pkg, slx_scan, slx_tokq and the assertion macro header.
module script_lexer_byte_stream #(
    parameter int POSITION_BITS      = slx_pkg::POSITION_BITS,
    parameter int KEYWORD_PREFIX_LEN = slx_pkg::KEYWORD_PREFIX_LEN
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_byte
    input  logic         s_tlast,   // end_of_input
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // [31:0] start_offset, [63:32] token_length,
                                    // [95:64] line_number
    output logic [7:0]   m_tuser,   // [5:0] token_kind, [7:6] error_kind
    output logic         m_tlast    // last_token
);
    import slx_pkg::*;

    `include "script_lexer_byte_stream_assert.svh"

    logic       in_beat;
    push_t      push;
    tok_t       head;
    tokq_stat_t tokq_stat;

    assign s_tready = tokq_stat.room;
    assign in_beat  = s_tvalid && s_tready;

    slx_scan #(
        .POS_BITS (POSITION_BITS),
        .KPL      (KEYWORD_PREFIX_LEN)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_beat      (in_beat),
        .char_byte    (s_tdata),
        .end_of_input (s_tlast),
        .push         (push)
    );

    slx_tokq #(
        .DEPTH (TOKQ_DEPTH)
    ) u_tokq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (in_beat),
        .push      (push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head),
        .stat      (tokq_stat)
    );

    // Output beat
    assign m_tdata = {head.line, head.len, head.start};
    assign m_tuser = {head.err, head.kind};
    assign m_tlast = head.last;

    // Checks
    `SLX_ASSERT_IMPLY(a_tokq_bound, aclk, aresetn, 1'b1, tokq_stat.count <= TOKQ_CNT_W'(TOKQ_DEPTH), "token queue overflow")
    `SLX_ASSERT_IMPLY(a_eof_last, aclk, aresetn, m_tvalid && (m_tuser[5:0] == K_EOF), m_tlast, "EOF token without last flag")
    `SLX_ASSERT_NEXT(a_end_queued, aclk, aresetn, s_tvalid && s_tready && s_tlast, tokq_stat.count != '0, "end of input left no token queued")

endmodule

>>> tb/sv/script_lexer_byte_stream_tb.sv
// Self-checking testbench for the streaming Lox scanner script_lexer_byte_stream.
// It drives a directed list of bytes and then random lexemes, and predicts each token internally.
// Depends on slx_pkg and the scanner RTL.
module script_lexer_byte_stream_tb;
    import slx_pkg::*;

    typedef struct {
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
        logic        last;
    } token_t;

    typedef struct {
        logic [7:0] b;
        logic       eoi;
    } src_beat_t;

    // Directed row: the expected token is typed in only where chk is set
    typedef struct {
        logic [7:0]  b;
        logic        eoi;
        logic        chk;
        logic [5:0]  kind;
        logic [1:0]  err;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
    } dir_row_t;

    typedef enum logic [3:0] {
        SC_IDLE, SC_SLASH, SC_COMMENT, SC_OP, SC_WORD, SC_INT, SC_INTDOT, SC_FRAC, SC_STR
    } scan_state_t;

    localparam int NUM_DIR = 23;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h20;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [7:0]   m_tuser;
    logic         m_tlast;

    int errors = 0;
    int accepted = 0;
    int cyc = 0;
    token_t    pending_tokens[$];
    src_beat_t src_bytes[$];

    // Predictor state
    scan_state_t st_mode;
    logic [7:0]  st_op;
    logic [31:0] st_pos;
    logic [31:0] st_start;
    logic [31:0] st_line;
    logic [7:0]  st_prefix[6];

    string    kw_text[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                              "or", "print", "return", "super", "this", "true", "var",
                              "while"};
    dir_row_t dir_rows[NUM_DIR];

    script_lexer_byte_stream dut (.*);

    always #4 aclk = ~aclk;

    // ---------------- predictor ----------------
    function automatic logic [31:0] span32(logic [31:0] a, logic [31:0] b);
        return (b >= a) ? b - a : 32'd0;
    endfunction

    function automatic logic [5:0] word_code(logic [31:0] n);
        logic hit;
        if (n > 6) return K_IDENT;
        for (int k = 0; k < 16; k++) begin
            hit = (kw_text[k].len() == n);
            for (int i = 0; i < kw_text[k].len(); i++)
                if (hit && st_prefix[i] != kw_text[k][i]) hit = 0;
            if (hit) return 6'(22 + k);
        end
        return K_IDENT;
    endfunction

    function automatic logic [5:0] rel_code(logic [7:0] op, bit eq);
        logic [5:0] base;
        base = (op == "!") ? K_BANG : (op == "=") ? K_EQUAL : (op == ">") ? K_GREATER : K_LESS;
        return base + 6'(eq);
    endfunction

    function automatic void add_token(ref token_t t[$], input logic [5:0] k, logic [1:0] e,
                                      logic [31:0] s, logic [31:0] n);
        t.push_back('{k, e, s, n, st_line, 1'b0});
    endfunction

    function automatic void flush_held(ref token_t t[$]);
        logic [31:0] n;
        logic [31:0] dot;
        n = span32(st_start, st_pos);
        dot = (st_pos != 0) ? st_pos - 1 : 32'd0;
        case (st_mode)
            SC_SLASH:        add_token(t, K_SLASH, E_NONE, st_start, 1);
            SC_OP:           add_token(t, rel_code(st_op, 0), E_NONE, st_start, 1);
            SC_WORD:         add_token(t, word_code(n), E_NONE, st_start, n);
            SC_INT, SC_FRAC: add_token(t, K_NUMBER, E_NONE, st_start, n);
            SC_INTDOT: begin
                add_token(t, K_NUMBER, E_NONE, st_start, span32(st_start, dot));
                add_token(t, K_DOT, E_NONE, dot, 1);
            end
            SC_STR:          add_token(t, K_ERROR, E_UNTERM, st_start, n);
            default: ;
        endcase
        st_mode = SC_IDLE;
    endfunction

    function automatic void start_lexeme(ref token_t t[$], input logic [7:0] c);
        logic [5:0] sk;
        if (c == " " || c == 8'h0D || c == 8'h09) return;
        if (c == 8'h0A) begin
            if (st_line != '1) st_line++;
            return;
        end
        st_start = st_pos;
        if (c == "/") st_mode = SC_SLASH;
        else if (is_alpha(c)) begin
            st_mode = SC_WORD;
            st_prefix[0] = c;
        end else if (is_digit(c)) st_mode = SC_INT;
        else if (c == "\"") st_mode = SC_STR;
        else if (c == "!" || c == "=" || c == "<" || c == ">") begin
            st_mode = SC_OP;
            st_op = c;
        end else begin
            sk = single_kind(c);
            add_token(t, sk, (sk == K_ERROR) ? E_UNEXPECTED : E_NONE, st_pos, 1);
        end
    endfunction

    function automatic void clear_scan();
        st_mode = SC_IDLE;
        st_op = 0;
        st_pos = 0;
        st_start = 0;
        st_line = 1;
    endfunction

    // Tokens caused by one accepted source byte
    function automatic void scan_byte(input logic [7:0] c, logic eoi, ref token_t t[$]);
        bit again;
        logic [31:0] n;
        again = 1;
        if (eoi || c == 0) begin
            flush_held(t);
            add_token(t, K_EOF, E_NONE, st_pos, 0);
            t[$].last = 1;
            clear_scan();
            return;
        end
        case (st_mode)
            SC_SLASH: if (c == "/") begin
                st_mode = SC_COMMENT;
                again = 0;
            end
            SC_COMMENT: if (c == 8'h0A) st_mode = SC_IDLE; else again = 0;
            SC_OP: if (c == "=") begin
                add_token(t, rel_code(st_op, 1), E_NONE, st_start, 2);
                st_mode = SC_IDLE;
                again = 0;
            end
            SC_WORD: if (is_alpha(c) || is_digit(c)) begin
                n = span32(st_start, st_pos);
                if (n < 6) st_prefix[n] = c;
                again = 0;
            end
            SC_INT: begin
                if (is_digit(c)) again = 0;
                else if (c == ".") begin
                    st_mode = SC_INTDOT;
                    again = 0;
                end
            end
            SC_INTDOT: if (is_digit(c)) begin
                st_mode = SC_FRAC;
                again = 0;
            end
            SC_FRAC: if (is_digit(c)) again = 0;
            SC_STR: begin
                again = 0;
                if (c == "\"") begin
                    n = span32(st_start, st_pos);
                    if (n != '1) n++;
                    add_token(t, K_STRING, E_NONE, st_start, n);
                    st_mode = SC_IDLE;
                end else if (c == 8'h0A && st_line != '1) st_line++;
            end
            default: ;
        endcase
        if (again) begin
            flush_held(t);
            start_lexeme(t, c);
        end
        if (st_pos != '1) st_pos++;
        if (t.size() > 0) t[$].last = 1;
    endfunction

    // ---------------- stimulus building ----------------
    function automatic void add_row(int i, logic [7:0] b, logic eoi, logic chk = 0,
                                    logic [5:0] k = 0, logic [1:0] e = 0,
                                    logic [31:0] s = 0, logic [31:0] n = 0,
                                    logic [31:0] ln = 1);
        dir_rows[i] = '{b, eoi, chk, k, e, s, n, ln};
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) src_bytes.push_back('{s[i], 1'b0});
    endfunction

    function automatic logic [7:0] rand_word_char(bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) return 8'("a") + 8'(r);
        if (r < 52) return 8'("A") + 8'(r - 26);
        if (r == 52) return "_";
        return 8'("0") + 8'(r - 53);
    endfunction

    // One random lexeme, mostly well-formed, sometimes noise or an end of input
    function automatic void add_lexeme();
        string ops = "!=<>";
        string puncts = "(){},.-+;*/";
        string blanks = " \t\r\n";
        int n;
        case ($urandom_range(0, 13))
            0, 1: put_str(kw_text[$urandom_range(0, 15)]);
            2, 3: begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
                src_bytes.push_back('{rand_word_char(1), 1'b0});
                repeat (n - 1) src_bytes.push_back('{rand_word_char(0), 1'b0});
            end
            4: begin
                repeat ($urandom_range(1, 4)) src_bytes.push_back('{8'("0") + 8'($urandom_range(0, 9)), 1'b0});
                case ($urandom_range(0, 2))
                    0: begin
                        put_str(".");
                        repeat ($urandom_range(1, 3)) src_bytes.push_back('{8'("0") + 8'($urandom_range(0, 9)), 1'b0});
                    end
                    1: put_str(".");
                    default: ;
                endcase
            end
            5: begin
                put_str("\"");
                repeat ($urandom_range(0, 6)) begin
                    n = $urandom_range(0, 9);
                    src_bytes.push_back('{(n == 0) ? 8'h0A : 8'($urandom_range(32, 126)) & 8'hDD | 8'h01, 1'b0});
                end
                if ($urandom_range(0, 5) != 0) put_str("\"");
            end
            6: begin
                src_bytes.push_back('{ops[$urandom_range(0, 3)], 1'b0});
                if ($urandom_range(0, 1)) put_str("=");
            end
            7: src_bytes.push_back('{puncts[$urandom_range(0, 10)], 1'b0});
            8: begin
                put_str("//");
                repeat ($urandom_range(0, 5)) src_bytes.push_back('{8'($urandom_range(1, 255)) & 8'hF5 | 8'h01, 1'b0});
                put_str("\n");
            end
            9, 10: src_bytes.push_back('{blanks[$urandom_range(0, 3)], 1'b0});
            11: src_bytes.push_back('{8'($urandom_range(1, 255)), 1'b0});
            default: begin
                if ($urandom_range(0, 3) == 0) src_bytes.push_back('{8'h00, 1'b0});
                else if ($urandom_range(0, 2) == 0) src_bytes.push_back('{8'($urandom_range(0, 255)), 1'b1});
                else put_str(" ");
            end
        endcase
        if ($urandom_range(0, 2) != 0) put_str(" ");
    endfunction

    // ---------------- checking ----------------
    always @(posedge aclk) begin
        token_t fresh[$];
        token_t want;
        dir_row_t row;
        fresh.delete();
        if (aresetn && s_tvalid && s_tready) begin
            scan_byte(s_tdata, s_tlast, fresh);
            if (accepted < NUM_DIR && dir_rows[accepted].chk) begin
                row = dir_rows[accepted];
                if (fresh.size() == 0 || fresh[0].kind != row.kind || fresh[0].err != row.err ||
                    fresh[0].start != row.start || fresh[0].len != row.len ||
                    fresh[0].line != row.line) begin
                    $display("%0t: directed beat %0d: expected kind %0d err %0d start %0d len %0d line %0d, predicted %p",
                             $time, accepted, row.kind, row.err, row.start, row.len, row.line, fresh);
                    errors++;
                end
            end
            foreach (fresh[i]) pending_tokens.push_back(fresh[i]);
            accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected token beat, actual data %h user %h last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = pending_tokens.pop_front();
                if (m_tuser[5:0] != want.kind || m_tuser[7:6] != want.err ||
                    m_tdata[31:0] != want.start || m_tdata[63:32] != want.len ||
                    m_tdata[95:64] != want.line || m_tlast != want.last) begin
                    $display("%0t: token mismatch: expected kind %0d err %0d start %0d len %0d line %0d last %b",
                             $time, want.kind, want.err, want.start, want.len, want.line, want.last);
                    $display("%0t:                 actual kind %0d err %0d start %0d len %0d line %0d last %b",
                             $time, m_tuser[5:0], m_tuser[7:6], m_tdata[31:0], m_tdata[63:32],
                             m_tdata[95:64], m_tlast);
                    errors++;
                end
            end
        end
    end

    // Receiver: stretches of full readiness alternate with random stalls
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc % 300 < 80) m_tready <= 1'b1;
        else if (cyc % 300 < 120) m_tready <= ($urandom_range(0, 5) == 0);
        else m_tready <= ($urandom_range(0, 2) != 0);
    end

    // ---------------- sender ----------------
    initial begin
        int burst;
        int n_rand;
        clear_scan();
        foreach (st_prefix[i]) st_prefix[i] = 0;

        add_row(0, "(", 0, 1, 6'd0, E_NONE, 0, 1, 1);
        add_row(1, 8'hFF, 0, 1, K_ERROR, E_UNEXPECTED, 1, 1, 1);
        add_row(2, "!", 0);
        add_row(3, "=", 0, 1, 6'd12, E_NONE, 2, 2, 1);
        add_row(4, "<", 0);
        add_row(5, "x", 0, 1, K_LESS, E_NONE, 4, 1, 1);
        add_row(6, "1", 0);
        add_row(7, ".", 0);
        add_row(8, "a", 0);       // number then dot, no fraction digit
        add_row(9, "/", 0);
        add_row(10, "/", 0);
        add_row(11, "z", 0);
        add_row(12, 8'h0A, 0);
        add_row(13, "/", 0);
        add_row(14, " ", 0);
        add_row(15, "\"", 0);
        add_row(16, "q", 0);
        add_row(17, 8'h0A, 0);
        add_row(18, 8'h00, 0, 1, K_ERROR, E_UNTERM, 15, 3, 3);   // zero byte inside string
        add_row(19, "o", 0);
        add_row(20, "r", 0);
        add_row(21, "{", 0);
        add_row(22, 8'hA5, 1, 1, K_EOF, E_NONE, 3, 0, 1);
        foreach (dir_rows[i]) src_bytes.push_back('{dir_rows[i].b, dir_rows[i].eoi});
        n_rand = src_bytes.size() + 245;
        while (src_bytes.size() < n_rand) add_lexeme();
        src_bytes.push_back('{8'h00, 1'b1});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst = $urandom_range(1, 30);
        foreach (src_bytes[i]) begin
            if (burst == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= src_bytes[i].b;
            s_tlast  <= src_bytes[i].eoi;
            do @(posedge aclk); while (!s_tready);
            burst--;
        end
        s_tvalid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_tokens.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/slx_pkg.sv
rtl/slx_scan.sv
rtl/slx_tokq.sv
rtl/script_lexer_byte_stream.sv
tb/sv/script_lexer_byte_stream_tb.sv
